@@ rtl/gbfs_pkg.sv @@
// Shared types, constants and helpers for the grid greedy best-first search block.
// No dependencies; used through scoped names by the top level, gbfs_cfg and gbfs_search.
package gbfs_pkg;

  localparam int GRID_WIDTH_DEF    = 8;
  localparam int GRID_HEIGHT_DEF   = 8;
  localparam int OPEN_DEPTH_DEF    = 256;
  localparam int HISTORY_DEPTH_DEF = 256;

  localparam int PATH_MAX_CELLS = 64;
  localparam int PATH_AW        = 6;
  localparam int PATH_CW        = 7;

  localparam int COORD_W     = 3;
  localparam int CELL_W      = 6;
  localparam int DIST_W      = 4;
  localparam int WALL_W      = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_WALL_MAP = 3'd0;
  localparam cfg_idx_t REG_START_X  = 3'd1;
  localparam cfg_idx_t REG_START_Y  = 3'd2;
  localparam cfg_idx_t REG_GOAL_X   = 3'd3;
  localparam cfg_idx_t REG_GOAL_Y   = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_GOAL      = 2'd0;
  localparam status_t STATUS_EXHAUSTED = 2'd1;
  localparam status_t STATUS_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [WALL_W-1:0]  wall_map;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROUND,
    S_SCAN,
    S_POP,
    S_MOVE,
    S_EXPAND,
    S_PATH,
    S_LINK,
    S_WALK,
    S_STORE,
    S_EMIT,
    S_LOAD,
    S_OUT
  } state_t;

  // Manhattan distance on 3-bit coordinates
  function automatic logic [DIST_W-1:0] cell_distance(
    input logic [COORD_W-1:0] x,
    input logic [COORD_W-1:0] y,
    input logic [COORD_W-1:0] gx,
    input logic [COORD_W-1:0] gy
  );
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    dx = (x >= gx) ? (x - gx) : (gx - x);
    dy = (y >= gy) ? (y - gy) : (gy - y);
    return DIST_W'(dx) + DIST_W'(dy);
  endfunction

endpackage

@@ rtl/grid_greedy_best_first_search_top.sv @@
// Operation: each search round starts, scans the open list for the entry nearest the goal,
// pops it into the history, compacts the open list behind it and expands the four neighbours
// (the goal round stops after its pop); then the final node is fetched, the history is walked
// back towards the start, the walk is closed and the results are emitted, one per path cell.
// Throughput: one request at a time; the single-read-port open-list RAM sets the pace.
// Reset: synchronous, active high; clears control and configuration, no clearing pass.
// Depends on gbfs_pkg, gbfs_cfg, gbfs_search, gbfs_ram.
module grid_greedy_best_first_search_top #(
  parameter int GRID_WIDTH    = gbfs_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT   = gbfs_pkg::GRID_HEIGHT_DEF,
  parameter int OPEN_DEPTH    = gbfs_pkg::OPEN_DEPTH_DEF,
  parameter int HISTORY_DEPTH = gbfs_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes: index 0 wall map, 1 start x, 2 start y, 3 goal x, 4 goal y
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gbfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbfs_pkg::WALL_W-1:0]         cfg_data,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [gbfs_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [0] begin_search
  // path result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [gbfs_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,  // [2:0] cell_x, [5:3] cell_y,
                                                              // [6] has_cell, [8:7] status
  output logic                                m_axis_tlast   // last
);

  gbfs_pkg::cfg_t cfg;

  logic [gbfs_pkg::COORD_W-1:0] out_x, out_y;
  logic                         out_has;
  gbfs_pkg::status_t            out_status;

  gbfs_cfg u_cfg (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cfg(cfg)
  );

  // a request with begin_search clear is taken and dropped
  gbfs_search #(
    .GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT),
    .OPEN_DEPTH(OPEN_DEPTH), .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_search (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_begin(s_axis_tdata[0]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_x(out_x), .out_y(out_y), .out_has(out_has),
    .out_status(out_status), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_status, out_has, out_y, out_x};

endmodule

@@ rtl/gbfs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/gbfs_cfg.sv @@
// Configuration register file for the search block (walls, start, goal).
// Depends on gbfs_pkg.
module gbfs_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gbfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbfs_pkg::WALL_W-1:0]    cfg_data,
  output gbfs_pkg::cfg_t             cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        gbfs_pkg::REG_WALL_MAP: cfg.wall_map <= cfg_data;
        gbfs_pkg::REG_START_X:  cfg.start_x  <= cfg_data[gbfs_pkg::COORD_W-1:0];
        gbfs_pkg::REG_START_Y:  cfg.start_y  <= cfg_data[gbfs_pkg::COORD_W-1:0];
        gbfs_pkg::REG_GOAL_X:   cfg.goal_x   <= cfg_data[gbfs_pkg::COORD_W-1:0];
        gbfs_pkg::REG_GOAL_Y:   cfg.goal_y   <= cfg_data[gbfs_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/gbfs_search.sv @@
// Search engine: open list, pop history and path stack in RAMs, driven by one FSM.
// Depends on gbfs_pkg and gbfs_ram.
module gbfs_search #(
  parameter int GRID_WIDTH    = gbfs_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT   = gbfs_pkg::GRID_HEIGHT_DEF,
  parameter int OPEN_DEPTH    = gbfs_pkg::OPEN_DEPTH_DEF,
  parameter int HISTORY_DEPTH = gbfs_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gbfs_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_begin,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [gbfs_pkg::COORD_W-1:0]     out_x,
  output logic [gbfs_pkg::COORD_W-1:0]     out_y,
  output logic                             out_has,
  output gbfs_pkg::status_t                out_status,
  output logic                             out_last
);

  localparam int OAW   = $clog2(OPEN_DEPTH);
  localparam int OCW   = $clog2(OPEN_DEPTH + 1);
  localparam int HAW   = $clog2(HISTORY_DEPTH);
  localparam int HCW   = $clog2(HISTORY_DEPTH + 1);
  localparam int CW    = gbfs_pkg::CELL_W;
  localparam int ENT_W = CW + HCW;

  gbfs_pkg::state_t state, state_next;

  logic [OCW-1:0]   open_count;
  logic [HCW-1:0]   hist_count;
  logic [OCW-1:0]   scan_ptr;
  logic [OCW-1:0]   best_idx;
  logic [gbfs_pkg::DIST_W-1:0] best_d;
  logic [ENT_W-1:0] best_ent;
  logic [OCW-1:0]   mv_ptr;
  logic             mv_pend;
  logic [OAW-1:0]   mv_addr;
  logic [CW-1:0]    cur_cell;
  logic [HAW-1:0]   cur_slot;
  logic [1:0]       nbr_k;
  gbfs_pkg::status_t status;
  logic [HCW-1:0]   link;
  logic [gbfs_pkg::PATH_CW-1:0] path_n;
  logic [gbfs_pkg::PATH_AW-1:0] e_ptr;
  logic [gbfs_pkg::WALL_W-1:0]  visited;

  // memory ports
  logic             open_we;
  logic [OAW-1:0]   open_waddr, open_raddr;
  logic [ENT_W-1:0] open_wdata, open_rdata;
  logic             hist_we;
  logic [HAW-1:0]   hist_raddr;
  logic [ENT_W-1:0] hist_rdata;
  logic             stk_we;
  logic [gbfs_pkg::PATH_AW-1:0] stk_raddr;
  logic [CW-1:0]    stk_rdata;

  gbfs_ram #(.WIDTH(ENT_W), .DEPTH(OPEN_DEPTH)) u_open (
    .clk(clk), .wr_en(open_we), .wr_addr(open_waddr), .wr_data(open_wdata),
    .rd_addr(open_raddr), .rd_data(open_rdata)
  );

  gbfs_ram #(.WIDTH(ENT_W), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk(clk), .wr_en(hist_we), .wr_addr(hist_count[HAW-1:0]), .wr_data(best_ent),
    .rd_addr(hist_raddr), .rd_data(hist_rdata)
  );

  gbfs_ram #(.WIDTH(CW), .DEPTH(gbfs_pkg::PATH_MAX_CELLS)) u_stack (
    .clk(clk), .wr_en(stk_we), .wr_addr(path_n[gbfs_pkg::PATH_AW-1:0]),
    .wr_data(hist_rdata[CW-1:0]), .rd_addr(stk_raddr), .rd_data(stk_rdata)
  );

  // scan: distance of the entry returned this cycle
  logic [gbfs_pkg::DIST_W-1:0] scan_d;
  assign scan_d = gbfs_pkg::cell_distance(open_rdata[2:0], open_rdata[5:3],
                                          cfg.goal_x, cfg.goal_y);

  // popped cell
  logic [CW-1:0] pop_bit;
  logic          pop_in, pop_goal;
  assign pop_in   = (4'(best_ent[2:0]) < 4'(GRID_WIDTH)) &&
                    (4'(best_ent[5:3]) < 4'(GRID_HEIGHT));
  assign pop_bit  = CW'(best_ent[5:3]) * CW'(GRID_WIDTH) + CW'(best_ent[2:0]);
  assign pop_goal = (best_ent[2:0] == cfg.goal_x) && (best_ent[5:3] == cfg.goal_y);

  // neighbour under test, order x-1, x+1, y-1, y+1
  logic [3:0]    nx, ny;
  logic [CW-1:0] nbr_bit;
  logic          nbr_ok;
  always_comb begin
    nx = {1'b0, cur_cell[2:0]};
    ny = {1'b0, cur_cell[5:3]};
    case (nbr_k)
      2'd0:    nx = nx - 4'd1;
      2'd1:    nx = nx + 4'd1;
      2'd2:    ny = ny - 4'd1;
      default: ny = ny + 4'd1;
    endcase
  end
  assign nbr_bit = CW'(ny[2:0]) * CW'(GRID_WIDTH) + CW'(nx[2:0]);
  assign nbr_ok  = (nx < 4'(GRID_WIDTH)) && (ny < 4'(GRID_HEIGHT)) &&
                   !cfg.wall_map[nbr_bit] && !visited[nbr_bit];

  logic [HCW-1:0] link_m1;
  logic           walk_ok;
  assign link_m1 = link - HCW'(1);
  assign walk_ok = (link != '0) && (path_n < gbfs_pkg::PATH_CW'(gbfs_pkg::PATH_MAX_CELLS)) &&
                   (link_m1 < hist_count);

  logic open_full, hist_full;
  assign open_full = open_count >= OCW'(OPEN_DEPTH);
  assign hist_full = hist_count >= HCW'(HISTORY_DEPTH);

  assign in_ready   = (state == gbfs_pkg::S_IDLE);
  assign out_status = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbfs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    open_we    = 1'b0;
    open_waddr = '0;
    open_wdata = {HCW'(0), cfg.start_y, cfg.start_x};
    open_raddr = scan_ptr[OAW-1:0];
    hist_we    = 1'b0;
    hist_raddr = cur_slot;
    stk_we     = 1'b0;
    stk_raddr  = e_ptr;
    case (state)
      gbfs_pkg::S_IDLE: begin
        if (in_valid && in_begin) begin
          open_we    = 1'b1;
          state_next = gbfs_pkg::S_ROUND;
        end
      end
      gbfs_pkg::S_ROUND: begin
        if (open_count == '0 || hist_full) begin
          state_next = gbfs_pkg::S_PATH;
        end else begin
          state_next = gbfs_pkg::S_SCAN;
        end
      end
      gbfs_pkg::S_SCAN: begin
        if (scan_ptr == open_count) begin
          state_next = gbfs_pkg::S_POP;
        end
      end
      gbfs_pkg::S_POP: begin
        hist_we    = 1'b1;
        state_next = pop_goal ? gbfs_pkg::S_PATH : gbfs_pkg::S_MOVE;
      end
      gbfs_pkg::S_MOVE: begin
        open_raddr = mv_ptr[OAW-1:0];
        open_we    = mv_pend;
        open_waddr = mv_addr;
        open_wdata = open_rdata;
        if (mv_ptr > open_count) begin
          state_next = gbfs_pkg::S_EXPAND;
        end
      end
      gbfs_pkg::S_EXPAND: begin
        open_waddr = open_count[OAW-1:0];
        open_wdata = {HCW'(cur_slot) + HCW'(1), ny[2:0], nx[2:0]};
        if (nbr_ok && open_full) begin
          state_next = gbfs_pkg::S_PATH;
        end else begin
          open_we = nbr_ok;
          if (nbr_k == 2'd3) begin
            state_next = gbfs_pkg::S_ROUND;
          end
        end
      end
      gbfs_pkg::S_PATH: begin
        state_next = gbfs_pkg::S_LINK;
      end
      gbfs_pkg::S_LINK: begin
        state_next = gbfs_pkg::S_WALK;
      end
      gbfs_pkg::S_WALK: begin
        hist_raddr = link_m1[HAW-1:0];
        state_next = walk_ok ? gbfs_pkg::S_STORE : gbfs_pkg::S_EMIT;
      end
      gbfs_pkg::S_STORE: begin
        stk_we     = 1'b1;
        state_next = gbfs_pkg::S_WALK;
      end
      gbfs_pkg::S_EMIT: begin
        stk_raddr  = gbfs_pkg::PATH_AW'(path_n - gbfs_pkg::PATH_CW'(1));
        state_next = (path_n == '0) ? gbfs_pkg::S_OUT : gbfs_pkg::S_LOAD;
      end
      gbfs_pkg::S_LOAD: begin
        state_next = gbfs_pkg::S_OUT;
      end
      gbfs_pkg::S_OUT: begin
        stk_raddr = e_ptr - gbfs_pkg::PATH_AW'(1);
        if (out_ready) begin
          state_next = out_last ? gbfs_pkg::S_IDLE : gbfs_pkg::S_LOAD;
        end
      end
      default: state_next = gbfs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_count <= '0;
      hist_count <= '0;
      visited    <= '0;
      out_valid  <= 1'b0;
      mv_pend    <= 1'b0;
      status     <= gbfs_pkg::STATUS_GOAL;
    end else begin
      case (state)
        gbfs_pkg::S_IDLE: begin
          if (in_valid && in_begin) begin
            open_count <= OCW'(1);
            hist_count <= '0;
            visited    <= '0;
            cur_slot   <= '0;
          end
        end
        gbfs_pkg::S_ROUND: begin
          scan_ptr <= '0;
          if (open_count == '0) begin
            status <= gbfs_pkg::STATUS_EXHAUSTED;
          end else if (hist_full) begin
            status <= gbfs_pkg::STATUS_OVERFLOW;
          end
        end
        gbfs_pkg::S_SCAN: begin
          if (scan_ptr != '0) begin
            if (scan_ptr == OCW'(1) || scan_d < best_d) begin
              best_d   <= scan_d;
              best_idx <= scan_ptr - OCW'(1);
              best_ent <= open_rdata;
            end
          end
          scan_ptr <= scan_ptr + OCW'(1);
        end
        gbfs_pkg::S_POP: begin
          hist_count <= hist_count + HCW'(1);
          cur_slot   <= hist_count[HAW-1:0];
          cur_cell   <= best_ent[CW-1:0];
          open_count <= open_count - OCW'(1);
          if (pop_in) begin
            visited[pop_bit] <= 1'b1;
          end
          if (pop_goal) begin
            status <= gbfs_pkg::STATUS_GOAL;
          end
          mv_ptr  <= best_idx + OCW'(1);
          mv_pend <= 1'b0;
        end
        gbfs_pkg::S_MOVE: begin
          if (mv_ptr <= open_count) begin
            mv_ptr  <= mv_ptr + OCW'(1);
            mv_pend <= 1'b1;
            mv_addr <= OAW'(mv_ptr - OCW'(1));
          end else begin
            mv_pend <= 1'b0;
            nbr_k   <= 2'd0;
          end
        end
        gbfs_pkg::S_EXPAND: begin
          if (nbr_ok && open_full) begin
            status <= gbfs_pkg::STATUS_OVERFLOW;
          end else if (nbr_ok) begin
            open_count <= open_count + OCW'(1);
          end
          nbr_k <= nbr_k + 2'd1;
        end
        gbfs_pkg::S_LINK: begin
          link   <= hist_rdata[ENT_W-1:CW];
          path_n <= '0;
        end
        gbfs_pkg::S_STORE: begin
          link   <= hist_rdata[ENT_W-1:CW];
          path_n <= path_n + gbfs_pkg::PATH_CW'(1);
        end
        gbfs_pkg::S_EMIT: begin
          e_ptr <= gbfs_pkg::PATH_AW'(path_n - gbfs_pkg::PATH_CW'(1));
          if (path_n == '0) begin
            out_x     <= '0;
            out_y     <= '0;
            out_has   <= 1'b0;
            out_last  <= 1'b1;
            out_valid <= 1'b1;
          end
        end
        gbfs_pkg::S_LOAD: begin
          out_x     <= stk_rdata[2:0];
          out_y     <= stk_rdata[5:3];
          out_has   <= 1'b1;
          out_last  <= (e_ptr == '0);
          out_valid <= 1'b1;
        end
        gbfs_pkg::S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            e_ptr     <= e_ptr - gbfs_pkg::PATH_AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/gbfs_checker.sv @@
// Port-level checker for the search block, bound to the top level.
// Depends on the top level's port list only.
module gbfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // no new request while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // empty path is a single result with zero cell
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[6] |-> m_axis_tlast && m_axis_tdata[5:0] == 6'd0)
    else $error("empty path result malformed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[8:7] != 2'd3)
    else $error("bad status code");

  // status stays the same across one search's results
  a_status_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |=> m_axis_tdata[8:7] == $past(m_axis_tdata[8:7]))
    else $error("status changed within a search");

endmodule

bind grid_greedy_best_first_search_top gbfs_checker u_gbfs_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

@@ bench/tb_top.sv @@
// Testbench for grid_greedy_best_first_search_top: directed table then random searches,
// each path checked against a behavioural greedy best-first predictor.
// Depends on gbfs_pkg and the rtl files.
`timescale 1ns / 1ps
module tb_top;

  localparam int GW = 8;
  localparam int GH = 8;
  localparam int OPEN_D = 256;
  localparam int HIST_D = 256;
  localparam int STALL_LIMIT = 1000000;

  typedef struct packed {
    logic [2:0]        x;
    logic [2:0]        y;
    logic              has;
    gbfs_pkg::status_t st;
    logic              lst;
  } path_cell_t;

  typedef struct {
    logic [63:0] walls;
    logic [2:0]  sx, sy, gx, gy;
    logic [7:0]  req;      // tdata of the request
    logic        chk;      // typed-in expectation present
    path_cell_t  known;    // typed-in single result
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  gbfs_pkg::cfg_idx_t cfg_index = gbfs_pkg::REG_WALL_MAP;
  logic [63:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tlast;

  // predictor copy of the registers
  logic [63:0] p_walls;
  logic [2:0]  p_sx, p_sy, p_gx, p_gy;

  path_cell_t path_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle = 0;   // percent
  int recv_stall = 0;  // percent

  grid_greedy_best_first_search_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic int manhattan(input int x, input int y);
    int dx, dy;
    dx = x - p_gx; dy = y - p_gy;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return dx + dy;
  endfunction

  // Greedy best-first search; queues the expected path cells.
  task automatic predict_path();
    int ox[$], oy[$], ol[$];
    int hx[HIST_D], hy[HIST_D], hl[HIST_D];
    logic [63:0] seen;
    int hcnt, fin, best, bd, d, nx, ny, b, link, n;
    int dxs[4], dys[4];
    int chx[$], chy[$];
    gbfs_pkg::status_t st;
    bit done;
    dxs = '{-1, 1, 0, 0};
    dys = '{0, 0, -1, 1};
    seen = '0; hcnt = 0; fin = 0; done = 0;
    st = gbfs_pkg::STATUS_GOAL;
    ox.insert(ox.size(), int'(p_sx)); oy.insert(oy.size(), int'(p_sy));
    ol.insert(ol.size(), 0);
    while (!done) begin
      if (ox.size() == 0) begin st = gbfs_pkg::STATUS_EXHAUSTED; break; end
      if (hcnt >= HIST_D) begin st = gbfs_pkg::STATUS_OVERFLOW; break; end
      best = 0; bd = manhattan(ox[0], oy[0]);
      for (int i = 1; i < ox.size(); i++) begin
        d = manhattan(ox[i], oy[i]);
        if (d < bd) begin bd = d; best = i; end
      end
      hx[hcnt] = ox[best]; hy[hcnt] = oy[best]; hl[hcnt] = ol[best];
      ox.delete(best); oy.delete(best); ol.delete(best);
      fin = hcnt; hcnt++;
      seen[hy[fin]*GW + hx[fin]] = 1'b1;
      if (hx[fin] == p_gx && hy[fin] == p_gy) begin st = gbfs_pkg::STATUS_GOAL; break; end
      for (int k = 0; k < 4; k++) begin
        nx = hx[fin] + dxs[k]; ny = hy[fin] + dys[k];
        if (nx < 0 || nx >= GW || ny < 0 || ny >= GH) continue;
        b = ny*GW + nx;
        if (p_walls[b] || seen[b]) continue;
        if (ox.size() >= OPEN_D) begin st = gbfs_pkg::STATUS_OVERFLOW; done = 1; break; end
        ox.insert(ox.size(), nx); oy.insert(oy.size(), ny); ol.insert(ol.size(), fin + 1);
      end
    end
    link = hl[fin];
    while (link != 0 && chx.size() < gbfs_pkg::PATH_MAX_CELLS) begin
      if (link - 1 >= hcnt) break;
      chx.push_front(hx[link-1]); chy.push_front(hy[link-1]);
      link = hl[link-1];
    end
    n = chx.size();
    if (n == 0) path_q.insert(path_q.size(), path_cell_t'{3'd0, 3'd0, 1'b0, st, 1'b1});
    for (int k = 0; k < n; k++)
      path_q.insert(path_q.size(),
                    path_cell_t'{chx[k][2:0], chy[k][2:0], 1'b1, st, k == n-1});
  endtask

  task automatic write_reg(input gbfs_pkg::cfg_idx_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gbfs_pkg::REG_WALL_MAP: p_walls = val;
      gbfs_pkg::REG_START_X:  p_sx = val[2:0];
      gbfs_pkg::REG_START_Y:  p_sy = val[2:0];
      gbfs_pkg::REG_GOAL_X:   p_gx = val[2:0];
      default:                p_gy = val[2:0];
    endcase
  endtask

  // wait for an idle block, with margin for a request that yields nothing
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (path_q.size() != 0) @(posedge clk);
    repeat (8000) @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] w, input logic [2:0] sx, sy, gx, gy);
    drain();
    write_reg(gbfs_pkg::REG_WALL_MAP, w);
    write_reg(gbfs_pkg::REG_START_X, {61'd0, sx});
    write_reg(gbfs_pkg::REG_START_Y, {61'd0, sy});
    write_reg(gbfs_pkg::REG_GOAL_X, {61'd0, gx});
    write_reg(gbfs_pkg::REG_GOAL_Y, {61'd0, gy});
    cfg_valid <= 1'b0;
  endtask

  // request stays valid after acceptance until the next one or an idle cycle
  task automatic send_request(input logic [7:0] data);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1; s_axis_tdata <= data;
    do @(posedge clk); while (!s_axis_tready);
    if (data[0]) predict_path();
  endtask

  // receiver: random stall, result check
  always @(posedge clk) begin
    path_cell_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[6],
                m_axis_tdata[8:7], m_axis_tlast};
        if (path_q.size() == 0) report_mismatch("result with nothing expected");
        else begin
          want = path_q.pop_front();
          if (got.x != want.x) report_mismatch("cell_x");
          if (got.y != want.y) report_mismatch("cell_y");
          if (got.has != want.has) report_mismatch("has_cell");
          if (got.st != want.st) report_mismatch("status");
          if (got.lst != want.lst) report_mismatch("tlast");
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog on cycles without any accepted request, configuration write or result
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("grid_greedy_best_first_search_top test failed");
      $finish;
    end
  end

  row_t dir_rows[$];

  initial begin
    row_t r;
    logic [2:0] sx, sy, gx, gy;
    logic [63:0] w;
    p_walls = '0; p_sx = '0; p_sy = '0; p_gx = '0; p_gy = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; only obvious rows carry a typed-in result
    // after reset: start equals goal, empty path
    dir_rows.insert(dir_rows.size(), row_t'{64'd0, 3'd0, 3'd0, 3'd0, 3'd0, 8'h01, 1'b1,
                    '{3'd0, 3'd0, 1'b0, gbfs_pkg::STATUS_GOAL, 1'b1}});
    // no request
    dir_rows.insert(dir_rows.size(), row_t'{64'd0, 3'd0, 3'd0, 3'd0, 3'd0, 8'hFE, 1'b0, '0});
    // neighbour goal: path is just the start
    dir_rows.insert(dir_rows.size(), row_t'{64'd0, 3'd7, 3'd7, 3'd6, 3'd7, 8'h01, 1'b1,
                    '{3'd7, 3'd7, 1'b1, gbfs_pkg::STATUS_GOAL, 1'b1}});
    // boxed-in start: exhausted, empty path
    dir_rows.insert(dir_rows.size(), row_t'{64'h0000_0000_0000_0102, 3'd0, 3'd0, 3'd7, 3'd7,
                    8'h01, 1'b1, '{3'd0, 3'd0, 1'b0, gbfs_pkg::STATUS_EXHAUSTED, 1'b1}});
    // long corner-to-corner runs, open field and extreme coordinates
    dir_rows.insert(dir_rows.size(), row_t'{64'd0, 3'd0, 3'd0, 3'd7, 3'd7, 8'h01, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), row_t'{64'd0, 3'd7, 3'd7, 3'd0, 3'd0, 8'hFF, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), row_t'{64'd0, 3'd7, 3'd0, 3'd0, 3'd7, 8'h01, 1'b0, '0});
    // start on a wall, goal on a wall
    dir_rows.insert(dir_rows.size(), row_t'{64'hFFFF_FFFF_FFFF_FFFF, 3'd3, 3'd3, 3'd5, 3'd5,
                    8'h01, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), row_t'{64'h8040_0000_0000_0000, 3'd0, 3'd0, 3'd7, 3'd7,
                    8'h01, 1'b0, '0});
    // wall columns forcing detours, alternating patterns
    dir_rows.insert(dir_rows.size(), row_t'{64'h0808_0808_0808_0800, 3'd0, 3'd0, 3'd7, 3'd0,
                    8'h01, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), row_t'{64'hAAAA_AAAA_AAAA_AAAA, 3'd0, 3'd0, 3'd0, 3'd7,
                    8'h01, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), row_t'{64'h5555_5555_5555_5555, 3'd1, 3'd0, 3'd7, 3'd7,
                    8'h01, 1'b0, '0});
    dir_rows.insert(dir_rows.size(), row_t'{64'h00FF_0000_FF00_0000, 3'd2, 3'd0, 3'd2, 3'd7,
                    8'h01, 1'b0, '0});

    send_idle = 0; recv_stall = 0;
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      configure(r.walls, r.sx, r.sy, r.gx, r.gy);
      send_request(r.req);
      if (r.chk && path_q.size() != 0 && path_q[$] != r.known)
        report_mismatch("predictor disagrees with table row");
    end

    // random phases; pause for a full drain between configurations
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 71; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 71; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      for (int n = 0; n < 30; n++) begin
        if (n % 3 == 0) begin
          case ($urandom_range(3))
            0: w = '0;
            1: w = {$urandom, $urandom} & {$urandom, $urandom};
            2: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: w = {$urandom, $urandom};
          endcase
          sx = 3'($urandom_range(7)); sy = 3'($urandom_range(7));
          gx = 3'($urandom_range(7)); gy = 3'($urandom_range(7));
          configure(w, sx, sy, gx, gy);
        end
        // mostly real requests, some ignored ones with random upper bits
        send_request({7'($urandom_range(127)), ($urandom_range(9) != 0)});
      end
    end

    s_axis_tvalid <= 1'b0;
    while (path_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("grid_greedy_best_first_search_top test passed");
    end else begin
      $display("grid_greedy_best_first_search_top test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/gbfs_pkg.sv
rtl/gbfs_ram.sv
rtl/gbfs_cfg.sv
rtl/gbfs_search.sv
rtl/grid_greedy_best_first_search_top.sv
rtl/gbfs_checker.sv
bench/tb_top.sv
